FILE: rtl/core/hsk_pkg.sv
// ----------------------------------------------------------------------------
// hsk_pkg
// Shared constants, controller states and control/status bundles of the
// hashed string key cache.
// ----------------------------------------------------------------------------
package hsk_pkg;

  localparam int SETS_DEF    = 256;
  localparam int WAYS_DEF    = 4;
  localparam int MAX_KEY_DEF = 64;
  localparam int HANDLE_BITS = 32;
  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 32;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_META  = 8'b0000_0100,
    S_LOAD  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_TAIL  = 8'b0010_0000,
    S_HND   = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } hsk_state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic meta_rd;
    logic load;
    logic issue;
    logic hnd_rd;
    logic res_load;
  } hsk_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic long_key;
    logic ins;
    logic idx_last;
    logic out_busy;
  } hsk_stat_t;

endpackage

FILE: rtl/core/hashed_string_key_cache_core.sv
// ----------------------------------------------------------------------------
// hashed_string_key_cache_core
// Set-associative string key cache with sdbm set hashing and round-robin
// replacement.
// ----------------------------------------------------------------------------
// Non-final key bytes are hashed and buffered while idle. Final byte of a key:
// set metadata read, one key store read per byte over all ways at once, then
// handle read and result register for a lookup; a long key is not stored as
// an insert and misses as a lookup. A result waiting in the output register
// stalls a lookup until it is taken.
// Reset: synchronous; a clearing pass over all sets empties all ways, with
// no item accepted until it ends.
// ----------------------------------------------------------------------------
module hashed_string_key_cache_core import hsk_pkg::*; #(
  parameter int SETS    = SETS_DEF,
  parameter int WAYS    = WAYS_DEF,
  parameter int MAX_KEY = MAX_KEY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [BYTE_W-1:0]      key_byte,
  input  logic                   key_last,
  input  logic [HANDLE_BITS-1:0] handler_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   hit,
  output logic [HANDLE_BITS-1:0] handler_out
);

  hsk_cmd_t  ctl;
  hsk_stat_t st;

  hsk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .key_last (key_last),
    .st       (st),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  hsk_dp #(.SETS(SETS), .WAYS(WAYS), .MAX_KEY(MAX_KEY)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .key_byte      (key_byte),
    .key_last      (key_last),
    .handler_value (handler_value),
    .out_ready     (out_ready),
    .ctl           (ctl),
    .st            (st),
    .out_valid     (out_valid),
    .hit           (hit),
    .handler_out   (handler_out)
  );

endmodule

FILE: rtl/core/hsk_ram.sv
// ----------------------------------------------------------------------------
// hsk_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module hsk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/hsk_ctrl.sv
// ----------------------------------------------------------------------------
// hsk_ctrl
// Controller: clearing pass, byte intake, set read, per-byte way scan or
// key copy, handle read and result hand-off.
// ----------------------------------------------------------------------------
module hsk_ctrl import hsk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      key_last,
  input  hsk_stat_t st,
  output logic      in_ready,
  output hsk_cmd_t  ctl
);

  hsk_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
        if (in_valid && key_last) state_next = S_META;
      end
      S_META: begin
        if (st.long_key) begin
          state_next = st.ins ? S_IDLE : S_RES;
        end else begin
          ctl.meta_rd = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        ctl.load   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.issue = 1'b1;
        if (st.idx_last) state_next = S_TAIL;
      end
      S_TAIL: begin
        state_next = st.ins ? S_IDLE : S_HND;
      end
      S_HND: begin
        ctl.hnd_rd = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (!st.out_busy) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

FILE: rtl/core/hsk_dp.sv
// ----------------------------------------------------------------------------
// hsk_dp
// Datapath: sdbm hash, key buffer, per-set metadata, key and handle stores,
// way-parallel byte compare and output register.
// ----------------------------------------------------------------------------
module hsk_dp import hsk_pkg::*; #(
  parameter int SETS    = SETS_DEF,
  parameter int WAYS    = WAYS_DEF,
  parameter int MAX_KEY = MAX_KEY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd,
  input  logic [BYTE_W-1:0]      key_byte,
  input  logic                   key_last,
  input  logic [HANDLE_BITS-1:0] handler_value,
  input  logic                   out_ready,
  input  hsk_cmd_t               ctl,
  output hsk_stat_t              st,
  output logic                   out_valid,
  output logic                   hit,
  output logic [HANDLE_BITS-1:0] handler_out
);

  localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int KB = $clog2(MAX_KEY);
  localparam int LB = $clog2(MAX_KEY + 1);
  localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MW = WAYS * LB + WB;

  logic [HASH_W-1:0]      hash, hash_next;
  logic [LB-1:0]          cnt, cnt_inc;
  logic                   pcmd, cur_cmd;
  logic [SB-1:0]          set_r, set_new, clr_a;
  logic [LB-1:0]          len_r;
  logic                   cmd_r;
  logic [HANDLE_BITS-1:0] hv_r;
  logic [WB-1:0]          way_r, ptr, ptr_nx, hit_way;
  logic [WAYS-1:0]        mv, mv_load, lane_eq;
  logic [KB-1:0]          idx, pidx;
  logic                   pend;

  logic [MW-1:0]            meta_rdata, meta_new, meta_wdata;
  logic [WAYS*BYTE_W-1:0]   ks_rdata, ks_wdata;
  logic [BYTE_W-1:0]        kb_rdata;
  logic [HANDLE_BITS-1:0]   hnd_rdata;

  assign cur_cmd   = (cnt == '0) ? cmd : pcmd;
  assign hash_next = HASH_W'(key_byte) + (hash << 6) + (hash << 16) - hash;
  assign cnt_inc   = (cnt < LB'(MAX_KEY)) ? cnt + LB'(1) : cnt;
  assign set_new   = (SETS > 1) ? hash_next[SB-1:0] : '0;

  assign ptr    = meta_rdata[WAYS*LB +: WB];
  assign ptr_nx = (ptr == WB'(WAYS - 1)) ? '0 : ptr + WB'(1);

  always_comb begin
    meta_new = meta_rdata;
    meta_new[ptr*LB +: LB] = len_r;
    meta_new[WAYS*LB +: WB] = ptr_nx;
    for (int w = 0; w < WAYS; w++) begin
      mv_load[w] = (meta_rdata[w*LB +: LB] == len_r) && (len_r != '0);
      lane_eq[w] = (ks_rdata[w*BYTE_W +: BYTE_W] == kb_rdata);
    end
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (mv[w]) hit_way = WB'(w);
    end
    ks_wdata = ks_rdata;
    ks_wdata[way_r*BYTE_W +: BYTE_W] = kb_rdata;
  end

  assign meta_wdata = ctl.clear ? '0 : meta_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= '0;
      cnt       <= '0;
      pcmd      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      clr_a     <= '0;
    end else begin
      pend <= ctl.issue;
      if (ctl.clear) clr_a <= clr_a + SB'(1);
      if (ctl.accept) begin
        if (key_last) begin
          hash <= '0;
          cnt  <= '0;
          pcmd <= 1'b0;
        end else begin
          hash <= hash_next;
          cnt  <= cnt_inc;
          pcmd <= cur_cmd;
        end
      end
      if (ctl.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && key_last) begin
      set_r <= set_new;
      len_r <= cnt_inc;
      cmd_r <= cur_cmd;
      hv_r  <= handler_value;
      mv    <= '0;
    end
    if (ctl.load) begin
      mv    <= mv_load;
      way_r <= ptr;
      idx   <= '0;
    end
    if (ctl.issue) begin
      idx  <= idx + KB'(1);
      pidx <= idx;
    end
    if (pend && !cmd_r) mv <= mv & lane_eq;
    if (ctl.res_load) begin
      hit         <= |mv;
      handler_out <= (|mv) ? hnd_rdata : '0;
    end
  end

  assign st.clr_done = (clr_a == SB'(SETS - 1));
  assign st.long_key = (len_r == LB'(MAX_KEY));
  assign st.ins      = cmd_r;
  assign st.idx_last = (idx == KB'(len_r - LB'(1)));
  assign st.out_busy = out_valid && !out_ready;

  hsk_ram #(.WIDTH(MW), .DEPTH(1 << SB)) u_meta (
    .clk   (clk),
    .we    (ctl.clear || (ctl.load && cmd_r)),
    .waddr (ctl.clear ? clr_a : set_r),
    .wdata (meta_wdata),
    .re    (ctl.meta_rd),
    .raddr (set_r),
    .rdata (meta_rdata)
  );

  hsk_ram #(.WIDTH(HANDLE_BITS), .DEPTH(1 << (SB + WB))) u_hnd (
    .clk   (clk),
    .we    (ctl.load && cmd_r),
    .waddr ({set_r, ptr}),
    .wdata (hv_r),
    .re    (ctl.hnd_rd),
    .raddr ({set_r, hit_way}),
    .rdata (hnd_rdata)
  );

  hsk_ram #(.WIDTH(WAYS * BYTE_W), .DEPTH(1 << (SB + KB))) u_keys (
    .clk   (clk),
    .we    (pend && cmd_r),
    .waddr ({set_r, pidx}),
    .wdata (ks_wdata),
    .re    (ctl.issue),
    .raddr ({set_r, idx}),
    .rdata (ks_rdata)
  );

  hsk_ram #(.WIDTH(BYTE_W), .DEPTH(1 << KB)) u_kbuf (
    .clk   (clk),
    .we    (ctl.accept && (cnt < LB'(MAX_KEY))),
    .waddr (cnt[KB-1:0]),
    .wdata (key_byte),
    .re    (ctl.issue),
    .raddr (idx),
    .rdata (kb_rdata)
  );

endmodule
